@@ rtl/core/bds_pkg.sv @@
`default_nettype none

package bds_pkg;

  // Colour channels carried per pixel
  localparam int CHANNELS = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_IDX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = 2'd2;

  // Register widths and reset values
  localparam int SCALE_CFG_W  = 4;
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;

  localparam logic [SCALE_CFG_W-1:0]  SCALE_RST  = 4'd1;
  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RST = 13'd480;

  // Output rows per frame are capped at this count
  localparam int MAX_OUT_HEIGHT = 4096;
  localparam int ROW_W          = 12;

endpackage

`default_nettype wire

@@ rtl/core/bds_pix_if.sv @@
`default_nettype none

interface bds_pix_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] red_sample;
  logic [SAMPLE_BITS-1:0] green_sample;
  logic [SAMPLE_BITS-1:0] blue_sample;
  logic                   frame_start;

  modport source (
    output valid, red_sample, green_sample, blue_sample, frame_start,
    input  ready
  );

  modport sink (
    input  valid, red_sample, green_sample, blue_sample, frame_start,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/bds_avg_if.sv @@
`default_nettype none

interface bds_avg_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] avg_red;
  logic [SAMPLE_BITS-1:0] avg_green;
  logic [SAMPLE_BITS-1:0] avg_blue;
  logic                   frame_last;

  modport source (
    output valid, avg_red, avg_green, avg_blue, frame_last,
    input  ready
  );

  modport sink (
    input  valid, avg_red, avg_green, avg_blue, frame_last,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/bds_line_store.sv @@
`default_nettype none

module bds_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 66
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bds_div.sv @@
`default_nettype none

// Three-stage divide of each channel sum by S*S, using a reciprocal
// multiply followed by one remainder correction.
module bds_div #(
  parameter int SUMW      = 22,
  parameter int MAX_SCALE = 8,
  parameter int SW        = 4
) (
  input  logic                                  clk,
  input  logic [SW-1:0]                         scale,
  input  logic [bds_pkg::CHANNELS-1:0][SUMW-1:0] dividend,
  output logic [bds_pkg::CHANNELS-1:0][SUMW-1:0] quotient
);

  import bds_pkg::*;

  localparam int RW = SUMW + 1;
  localparam int NW = $clog2(MAX_SCALE * MAX_SCALE + 1);
  localparam int PW = SUMW + RW;

  logic [RW-1:0] recip_tab [MAX_SCALE+1];
  logic [NW-1:0] sq_tab    [MAX_SCALE+1];

  // Build floor(2^SUMW / (s*s)) and s*s for every block side
  for (genvar g = 0; g <= MAX_SCALE; g++) begin : g_tab
    localparam longint unsigned SQ = (g == 0) ? 64'd1 : longint'(g) * longint'(g);
    localparam longint unsigned RC = (64'd1 << SUMW) / SQ;
    assign recip_tab[g] = RW'(RC);
    assign sq_tab[g]    = NW'(SQ);
  end

  logic [CHANNELS-1:0][PW-1:0]   prod_r;
  logic [CHANNELS-1:0][SUMW-1:0] x1_r;
  logic [NW-1:0]                 n1_r;
  logic [CHANNELS-1:0][SUMW-1:0] q0_r;
  logic [CHANNELS-1:0][SUMW-1:0] qn_r;
  logic [CHANNELS-1:0][SUMW-1:0] x2_r;
  logic [NW-1:0]                 n2_r;
  logic [CHANNELS-1:0][SUMW-1:0] rem;

  // Stage 1: multiply by the reciprocal
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      prod_r[c] <= PW'(dividend[c]) * PW'(recip_tab[scale]);
      x1_r[c]   <= dividend[c];
    end
    n1_r <= sq_tab[scale];
  end

  // Stage 2: estimate is exact or one short; multiply it back
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      q0_r[c] <= prod_r[c][SUMW +: SUMW];
      qn_r[c] <= SUMW'(prod_r[c][SUMW +: SUMW] * SUMW'(n1_r));
      x2_r[c] <= x1_r[c];
    end
    n2_r <= n1_r;
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      rem[c] = x2_r[c] - qn_r[c];
    end
  end

  // Stage 3: bump the estimate where the remainder reaches the divisor
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (rem[c] >= SUMW'(n2_r)) begin
        quotient[c] <= q0_r[c] + SUMW'(1);
      end else begin
        quotient[c] <= q0_r[c];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/box_downsample_rgb_core.sv @@
`default_nettype none

// Streaming box-filter downsampler: takes supersampled RGB pixels (unsigned Q8.8) in
// raster order and emits one pixel per S x S block, each channel the block sum divided
// by S*S and truncated, with frame_last set on the final block of a frame. Per-column
// running sums live in a single-port-write, registered-read line store; each item is a
// read, modify and write-back of one entry, so the block works on one item at a time:
// an item that ends no block passes through the line store update alone, and one that
// ends a block through the line store update, three divider stages, then the output
// register, which waits while a previous result is still held there. After reset, all
// MAX_OUT_WIDTH line store entries are zeroed in a clearing pass that accepts no item;
// configuration writes are taken at any time and should be made while the block is idle.
module box_downsample_rgb_core #(
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_SCALE     = 8,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bds_pix_if.sink                           in_pix,
  bds_avg_if.source                         out_avg,
  input  logic                              cfg_we,
  input  logic [bds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import bds_pkg::*;

  localparam int OCW  = $clog2(MAX_OUT_WIDTH);
  localparam int SCW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int SW   = $clog2(MAX_SCALE + 1);
  localparam int SUMW = SAMPLE_BITS + 2 * $clog2(MAX_SCALE);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
  localparam logic [ST_W-1:0] ST_UPD   = 3'd2;
  localparam logic [ST_W-1:0] ST_D1    = 3'd3;
  localparam logic [ST_W-1:0] ST_D2    = 3'd4;
  localparam logic [ST_W-1:0] ST_D3    = 3'd5;
  localparam logic [ST_W-1:0] ST_OUT   = 3'd6;

  logic [ST_W-1:0]         state_r, state_nxt;
  logic [OCW-1:0]          clr_addr_r;

  logic [SCALE_CFG_W-1:0]  scale_r;
  logic [WIDTH_CFG_W-1:0]  width_r;
  logic [HEIGHT_CFG_W-1:0] height_r;

  logic [SCW-1:0]          sub_col_r, sub_col_nxt;
  logic [OCW-1:0]          out_col_r, out_col_nxt;
  logic [SCW-1:0]          sub_row_r, sub_row_nxt;
  logic [ROW_W-1:0]        out_row_r, out_row_nxt;

  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] samp_r;
  logic [OCW-1:0]          idx_r;
  logic                    first_r;
  logic                    emit_r;
  logic                    flast_r;

  logic [CHANNELS-1:0][SUMW-1:0] sum_r;
  logic [CHANNELS-1:0][SUMW-1:0] new_sum;
  logic [CHANNELS-1:0][SUMW-1:0] rd_sum;
  logic [CHANNELS-1:0][SUMW-1:0] wr_sum;
  logic [CHANNELS-1:0][SUMW-1:0] quotient;

  logic                    out_valid_r;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] avg_r;
  logic                    out_last_r;

  logic [SW-1:0]           s_eff;
  logic [SCW-1:0]          s_last;
  logic [OCW-1:0]          w_last;
  logic [ROW_W-1:0]        h_last;

  logic [SCW-1:0]          cur_sc;
  logic [OCW-1:0]          cur_oc;
  logic [SCW-1:0]          cur_sr;
  logic [ROW_W-1:0]        cur_or;
  logic                    last_sc, last_oc, last_sr, last_or;

  logic                    accept;
  logic                    out_load;
  logic                    wr_en;
  logic [OCW-1:0]          wr_addr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCALE_IDX:  scale_r  <= cfg_data[SCALE_CFG_W-1:0];
        CFG_WIDTH_IDX:  width_r  <= cfg_data[WIDTH_CFG_W-1:0];
        CFG_HEIGHT_IDX: height_r <= cfg_data[HEIGHT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to their usable ranges
  always_comb begin
    if (scale_r == '0) begin
      s_eff = SW'(1);
    end else if (32'(scale_r) > 32'(MAX_SCALE)) begin
      s_eff = SW'(MAX_SCALE);
    end else begin
      s_eff = SW'(scale_r);
    end
    s_last = SCW'(s_eff - SW'(1));

    if (width_r == '0) begin
      w_last = '0;
    end else if (32'(width_r) > 32'(MAX_OUT_WIDTH)) begin
      w_last = OCW'(MAX_OUT_WIDTH - 1);
    end else begin
      w_last = OCW'(32'(width_r) - 32'd1);
    end

    if (height_r == '0) begin
      h_last = '0;
    end else if (32'(height_r) > 32'(MAX_OUT_HEIGHT)) begin
      h_last = ROW_W'(MAX_OUT_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(32'(height_r) - 32'd1);
    end
  end

  assign in_pix.ready = (state_r == ST_IDLE);
  assign accept       = in_pix.valid && (state_r == ST_IDLE);

  // Position of the incoming item; frame start restarts all counters
  always_comb begin
    cur_sc  = in_pix.frame_start ? '0 : sub_col_r;
    cur_oc  = in_pix.frame_start ? '0 : out_col_r;
    cur_sr  = in_pix.frame_start ? '0 : sub_row_r;
    cur_or  = in_pix.frame_start ? '0 : out_row_r;
    last_sc = cur_sc >= s_last;
    last_oc = cur_oc >= w_last;
    last_sr = cur_sr >= s_last;
    last_or = cur_or >= h_last;
  end

  // Advance the raster counters
  always_comb begin
    sub_col_nxt = sub_col_r;
    out_col_nxt = out_col_r;
    sub_row_nxt = sub_row_r;
    out_row_nxt = out_row_r;
    if (accept) begin
      sub_col_nxt = cur_sc;
      out_col_nxt = cur_oc;
      sub_row_nxt = cur_sr;
      out_row_nxt = cur_or;
      if (!last_sc) begin
        sub_col_nxt = cur_sc + SCW'(1);
      end else begin
        sub_col_nxt = '0;
        if (!last_oc) begin
          out_col_nxt = cur_oc + OCW'(1);
        end else begin
          out_col_nxt = '0;
          if (!last_sr) begin
            sub_row_nxt = cur_sr + SCW'(1);
          end else begin
            sub_row_nxt = '0;
            if (!last_or) begin
              out_row_nxt = cur_or + ROW_W'(1);
            end else begin
              out_row_nxt = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_col_r <= '0;
      out_col_r <= '0;
      sub_row_r <= '0;
      out_row_r <= '0;
    end else begin
      sub_col_r <= sub_col_nxt;
      out_col_r <= out_col_nxt;
      sub_row_r <= sub_row_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Hold the accepted item while its column entry is read
  always_ff @(posedge clk) begin
    if (accept) begin
      samp_r[0] <= in_pix.red_sample;
      samp_r[1] <= in_pix.green_sample;
      samp_r[2] <= in_pix.blue_sample;
      idx_r     <= cur_oc;
      first_r   <= (cur_sc == '0) && (cur_sr == '0);
      emit_r    <= last_sc && last_sr;
      flast_r   <= last_oc && last_or;
    end
  end

  // First sample of a block replaces the stored sum, later ones add to it
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (first_r) begin
        new_sum[c] = SUMW'(samp_r[c]);
      end else begin
        new_sum[c] = rd_sum[c] + SUMW'(samp_r[c]);
      end
    end
  end

  // Line store write: zero fill after reset, write-back in the update cycle.
  // One item is in flight at a time, so a read never meets a pending write.
  always_comb begin
    wr_en   = (state_r == ST_CLEAR) || (state_r == ST_UPD);
    wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : idx_r;
    wr_sum  = (state_r == ST_CLEAR) ? '0 : new_sum;
  end

  bds_line_store #(
    .DEPTH (MAX_OUT_WIDTH),
    .AW    (OCW),
    .DW    (CHANNELS * SUMW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_sum),
    .rd_en   (accept),
    .rd_addr (cur_oc),
    .rd_data (rd_sum)
  );

  // Hold the finished block sums at the divider input
  always_ff @(posedge clk) begin
    if ((state_r == ST_UPD) && emit_r) begin
      sum_r <= new_sum;
    end
  end

  bds_div #(
    .SUMW      (SUMW),
    .MAX_SCALE (MAX_SCALE),
    .SW        (SW)
  ) u_div (
    .clk      (clk),
    .scale    (s_eff),
    .dividend (sum_r),
    .quotient (quotient)
  );

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_avg.ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_addr_r == OCW'(MAX_OUT_WIDTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = emit_r ? ST_D1 : ST_IDLE;
      ST_D1:    state_nxt = ST_D2;
      ST_D2:    state_nxt = ST_D3;
      ST_D3:    state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + OCW'(1);
      end
    end
  end

  // Output register: load a finished item, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_avg.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int c = 0; c < CHANNELS; c++) begin
        avg_r[c] <= quotient[c][SAMPLE_BITS-1:0];
      end
      out_last_r <= flast_r;
    end
  end

  assign out_avg.valid      = out_valid_r;
  assign out_avg.avg_red    = avg_r[0];
  assign out_avg.avg_green  = avg_r[1];
  assign out_avg.avg_blue   = avg_r[2];
  assign out_avg.frame_last = out_last_r;

endmodule

`default_nettype wire

@@ rtl/core/bds_checker.sv @@
`default_nettype none

module bds_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_red,
  input logic [SAMPLE_BITS-1:0] out_green,
  input logic [SAMPLE_BITS-1:0] out_blue,
  input logic                   out_last
);

  // No item is taken in the cycle after reset: the line store is being cleared
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready straight after reset");

  // An accepted item keeps the block busy, so input ready drops after each accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready in the cycle after an accepted item");

  // A new result appears only as the sequencer leaves its output state
  a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the block was idle");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind box_downsample_rgb_core bds_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_avg.valid),
  .out_ready (out_avg.ready),
  .out_red   (out_avg.avg_red),
  .out_green (out_avg.avg_green),
  .out_blue  (out_avg.avg_blue),
  .out_last  (out_avg.frame_last)
);

`default_nettype wire
